// ===== hw/rtl/script_token_lexer_macros.svh =====
// Assertion helpers for the lexer RTL, included by stl_back.
`ifndef SCRIPT_TOKEN_LEXER_MACROS_SVH
`define SCRIPT_TOKEN_LEXER_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define STL_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication checked on the next clock edge.
`define STL_ASSERT_NEXT(name, cond, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error(msg);

`endif

// ===== hw/rtl/stl_pkg.sv =====
package stl_pkg;

  localparam int unsigned RunDepth  = 4;
  localparam int unsigned MaxRes    = 4;
  localparam logic [15:0] OffsetCap = 16'hFFFF;

  localparam logic [5:0] K_INVALID    = 6'd0;
  localparam logic [5:0] K_EOF        = 6'd1;
  localparam logic [5:0] K_COMMENT    = 6'd2;
  localparam logic [5:0] K_WHITESPACE = 6'd3;
  localparam logic [5:0] K_IDENT      = 6'd4;
  localparam logic [5:0] K_INTEGER    = 6'd5;
  localparam logic [5:0] K_NUMBER     = 6'd6;
  localparam logic [5:0] K_LSTR       = 6'd7;
  localparam logic [5:0] K_RSTR       = 6'd8;
  localparam logic [5:0] K_SPAN       = 6'd9;
  localparam logic [5:0] K_FN         = 6'd10;
  localparam logic [5:0] K_VAR        = 6'd11;
  localparam logic [5:0] K_CONST      = 6'd12;
  localparam logic [5:0] K_IF         = 6'd13;
  localparam logic [5:0] K_ELSE       = 6'd14;
  localparam logic [5:0] K_FOR        = 6'd15;
  localparam logic [5:0] K_WHILE      = 6'd16;
  localparam logic [5:0] K_TRY        = 6'd17;
  localparam logic [5:0] K_CATCH      = 6'd18;
  localparam logic [5:0] K_RETURN     = 6'd19;
  localparam logic [5:0] K_BREAK      = 6'd20;
  localparam logic [5:0] K_CONTINUE   = 6'd21;
  localparam logic [5:0] K_NONE       = 6'd23;
  localparam logic [5:0] K_TRUE       = 6'd24;
  localparam logic [5:0] K_FALSE      = 6'd25;
  localparam logic [5:0] K_IS         = 6'd26;
  localparam logic [5:0] K_AS         = 6'd27;
  localparam logic [5:0] K_TYPEOF     = 6'd28;
  localparam logic [5:0] K_AND        = 6'd29;
  localparam logic [5:0] K_OR         = 6'd30;
  localparam logic [5:0] K_NOT        = 6'd31;
  localparam logic [5:0] K_LPAREN     = 6'd32;
  localparam logic [5:0] K_RPAREN     = 6'd33;
  localparam logic [5:0] K_LBRACKET   = 6'd34;
  localparam logic [5:0] K_RBRACKET   = 6'd35;
  localparam logic [5:0] K_LBRACE     = 6'd36;
  localparam logic [5:0] K_RBRACE     = 6'd37;
  localparam logic [5:0] K_COMMA      = 6'd38;
  localparam logic [5:0] K_HASH       = 6'd39;
  localparam logic [5:0] K_DOT        = 6'd40;
  localparam logic [5:0] K_COLON      = 6'd41;
  localparam logic [5:0] K_SEMICOLON  = 6'd42;
  localparam logic [5:0] K_ASSIGN     = 6'd43;
  localparam logic [5:0] K_EQ         = 6'd44;
  localparam logic [5:0] K_NEQ        = 6'd45;
  localparam logic [5:0] K_LT         = 6'd46;
  localparam logic [5:0] K_LTEQ       = 6'd47;
  localparam logic [5:0] K_GT         = 6'd48;
  localparam logic [5:0] K_GTEQ       = 6'd49;
  localparam logic [5:0] K_PLUS       = 6'd50;
  localparam logic [5:0] K_MINUS      = 6'd51;
  localparam logic [5:0] K_STAR       = 6'd52;
  localparam logic [5:0] K_SLASH      = 6'd53;
  localparam logic [5:0] K_PERCENT    = 6'd54;
  localparam logic [5:0] K_TILDE      = 6'd55;
  localparam logic [5:0] K_AMPERSAND  = 6'd56;
  localparam logic [5:0] K_PIPE       = 6'd57;
  localparam logic [5:0] K_CARET      = 6'd58;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       byte_valid;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  token_kind;
    logic [15:0] token_start;
    logic [15:0] token_length;
    logic        lex_error;
    logic        last_of_run;
  } res_t;

  // All results caused by one input item.
  typedef struct packed {
    logic [$clog2(MaxRes)-1:0] last_idx;
    res_t [MaxRes-1:0]         res;
  } run_t;

endpackage

// ===== hw/rtl/stl_front.sv =====
module stl_front
  import stl_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_ready_i,
  input  in_item_t in_item_i,
  output logic     push_o,
  output run_t     run_o
);

  localparam logic [3:0] M_IDLE    = 4'd0;
  localparam logic [3:0] M_SPACE   = 4'd1;
  localparam logic [3:0] M_LINE    = 4'd2;
  localparam logic [3:0] M_BLOCK   = 4'd3;
  localparam logic [3:0] M_IDENT   = 4'd4;
  localparam logic [3:0] M_INT     = 4'd5;
  localparam logic [3:0] M_INT_DOT = 4'd6;
  localparam logic [3:0] M_FRAC    = 4'd7;
  localparam logic [3:0] M_STRING  = 4'd8;
  localparam logic [3:0] M_SLASH   = 4'd9;
  localparam logic [3:0] M_EQ      = 4'd10;
  localparam logic [3:0] M_BANG    = 4'd11;
  localparam logic [3:0] M_LT      = 4'd12;
  localparam logic [3:0] M_GT      = 4'd13;

  typedef struct packed {
    logic [1:0] n;
    res_t       a;
    res_t       b;
  } flush_t;

  logic [3:0]  mode_q, mode_d;
  logic [15:0] start_q, start_d;
  logic [15:0] off_q, off_d;
  logic [15:0] len_q, len_d;
  logic [15:0] dot_q, dot_d;
  logic [7:0]  la_q, la_d;
  logic        la_cnt_q, la_cnt_d;
  logic [63:0] kw_q, kw_d;
  logic        esc_q, esc_d;
  logic [2:0]  n_res;
  res_t [MaxRes-1:0] res;
  logic        accept;

  function automatic res_t mk(logic [5:0] k, logic [15:0] s, logic [15:0] l, logic e);
    res_t r;
    r.token_kind   = k;
    r.token_start  = s;
    r.token_length = l;
    r.lex_error    = e;
    r.last_of_run  = 1'b0;
    return r;
  endfunction

  function automatic logic [15:0] sat_add(logic [15:0] v, logic [1:0] d);
    logic [16:0] s;
    s = {1'b0, v} + {15'd0, d};
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

  function automatic logic [15:0] off_inc(logic [15:0] v);
    return (v < OffsetCap) ? v + 16'd1 : OffsetCap;
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  // The buffer holds the first byte in its low bits, so the literals are reversed.
  function automatic logic [5:0] kw_kind(logic [63:0] kb, logic [15:0] l);
    logic [5:0] k;
    k = K_IDENT;
    case (l)
      16'd2: begin
        if (kb == 64'("nf")) k = K_FN;
        else if (kb == 64'("fi")) k = K_IF;
        else if (kb == 64'("si")) k = K_IS;
        else if (kb == 64'("sa")) k = K_AS;
        else if (kb == 64'("ro")) k = K_OR;
      end
      16'd3: begin
        if (kb == 64'("rav")) k = K_VAR;
        else if (kb == 64'("rof")) k = K_FOR;
        else if (kb == 64'("yrt")) k = K_TRY;
        else if (kb == 64'("dna")) k = K_AND;
        else if (kb == 64'("ton")) k = K_NOT;
      end
      16'd4: begin
        if (kb == 64'("esle")) k = K_ELSE;
        else if (kb == 64'("enon")) k = K_NONE;
        else if (kb == 64'("eurt")) k = K_TRUE;
      end
      16'd5: begin
        if (kb == 64'("tsnoc")) k = K_CONST;
        else if (kb == 64'("elihw")) k = K_WHILE;
        else if (kb == 64'("hctac")) k = K_CATCH;
        else if (kb == 64'("kaerb")) k = K_BREAK;
        else if (kb == 64'("eslaf")) k = K_FALSE;
      end
      16'd6: begin
        if (kb == 64'("nruter")) k = K_RETURN;
        else if (kb == 64'("foepyt")) k = K_TYPEOF;
      end
      16'd8: begin
        if (kb == 64'("eunitnoc")) k = K_CONTINUE;
      end
      default: k = K_IDENT;
    endcase
    return k;
  endfunction

  function automatic logic [5:0] punct_kind(logic [7:0] c);
    logic [5:0] k;
    case (c)
      "(":     k = K_LPAREN;
      ")":     k = K_RPAREN;
      "[":     k = K_LBRACKET;
      "]":     k = K_RBRACKET;
      "{":     k = K_LBRACE;
      "}":     k = K_RBRACE;
      ",":     k = K_COMMA;
      "#":     k = K_HASH;
      ".":     k = K_DOT;
      ":":     k = K_COLON;
      ";":     k = K_SEMICOLON;
      "+":     k = K_PLUS;
      "-":     k = K_MINUS;
      "*":     k = K_STAR;
      "%":     k = K_PERCENT;
      "~":     k = K_TILDE;
      "&":     k = K_AMPERSAND;
      "|":     k = K_PIPE;
      "^":     k = K_CARET;
      default: k = K_INVALID;
    endcase
    return k;
  endfunction

  function automatic flush_t flush_f(logic [3:0] m, logic [15:0] s, logic [15:0] l,
                                     logic [15:0] d, logic [63:0] kb);
    flush_t f;
    f.n = 2'd1;
    f.a = mk(K_INVALID, s, 16'd1, 1'b0);
    f.b = mk(K_DOT, d, 16'd1, 1'b0);
    case (m)
      M_SPACE:   f.a = mk(K_WHITESPACE, s, l, 1'b0);
      M_LINE:    f.a = mk(K_COMMENT, s, l, 1'b0);
      M_BLOCK:   f.a = mk(K_COMMENT, s, l, 1'b0);
      M_IDENT:   f.a = mk((l > 16'd8) ? K_IDENT : kw_kind(kb, l), s, l, 1'b0);
      M_INT:     f.a = mk(K_INTEGER, s, l, 1'b0);
      M_INT_DOT: begin
        f.a = mk(K_INTEGER, s, l, 1'b0);
        f.n = 2'd2;
      end
      M_FRAC:    f.a = mk(K_NUMBER, s, l, 1'b0);
      M_STRING:  f.a = mk(K_INVALID, s, l, 1'b1);
      M_SLASH:   f.a = mk(K_SLASH, s, 16'd1, 1'b0);
      M_EQ:      f.a = mk(K_ASSIGN, s, 16'd1, 1'b0);
      M_BANG:    f.a = mk(K_INVALID, s, 16'd1, 1'b0);
      M_LT:      f.a = mk(K_LT, s, 16'd1, 1'b0);
      M_GT:      f.a = mk(K_GT, s, 16'd1, 1'b0);
      default:   f.n = 2'd0;
    endcase
    return f;
  endfunction

  assign accept = in_valid_i && in_ready_i;

  always_comb begin
    logic [7:0] c;
    logic       fall;
    logic       err;
    flush_t     f;
    c        = in_item_i.char_byte;
    fall     = 1'b0;
    err      = 1'b0;
    f        = '0;
    mode_d   = mode_q;
    start_d  = start_q;
    off_d    = off_q;
    len_d    = len_q;
    dot_d    = dot_q;
    la_d     = la_q;
    la_cnt_d = la_cnt_q;
    kw_d     = kw_q;
    esc_d    = esc_q;
    n_res    = 3'd0;
    res      = '0;

    if (in_item_i.byte_valid) begin
      case (mode_d)
        M_SPACE: begin
          if (is_space(c)) len_d = sat_add(len_d, 2'd1);
          else fall = 1'b1;
        end
        M_LINE: begin
          if (c != 8'h0A) len_d = sat_add(len_d, 2'd1);
          else fall = 1'b1;
        end
        M_BLOCK: begin
          len_d = sat_add(len_d, 2'd1);
          if (la_cnt_d && la_d == "*" && c == "/") begin
            res[n_res[1:0]] = mk(K_COMMENT, start_d, len_d, 1'b0);
            n_res    = n_res + 3'd1;
            mode_d   = M_IDLE;
            la_cnt_d = 1'b0;
            esc_d    = 1'b0;
          end else begin
            la_d     = c;
            la_cnt_d = (c == "*");
          end
        end
        M_IDENT: begin
          if (is_alpha(c) || is_digit(c) || c == "_") begin
            if (len_d < 16'd8) kw_d[{len_d[2:0], 3'b000} +: 8] = c;
            len_d = sat_add(len_d, 2'd1);
          end else begin
            fall = 1'b1;
          end
        end
        M_INT: begin
          if (is_digit(c)) begin
            len_d = sat_add(len_d, 2'd1);
          end else if (c == ".") begin
            mode_d   = M_INT_DOT;
            dot_d    = off_d;
            la_d     = c;
            la_cnt_d = 1'b1;
          end else begin
            fall = 1'b1;
          end
        end
        M_INT_DOT: begin
          if (is_digit(c)) begin
            len_d    = sat_add(len_d, 2'd2);
            mode_d   = M_FRAC;
            la_cnt_d = 1'b0;
          end else begin
            fall = 1'b1;
          end
        end
        M_FRAC: begin
          if (is_digit(c)) len_d = sat_add(len_d, 2'd1);
          else fall = 1'b1;
        end
        M_STRING: begin
          if (esc_d) begin
            esc_d = 1'b0;
            len_d = sat_add(len_d, 2'd1);
          end else if (c == "\"") begin
            res[n_res[1:0]] = mk(K_SPAN, start_d, len_d, 1'b0);
            n_res = n_res + 3'd1;
            res[n_res[1:0]] = mk(K_RSTR, off_d, 16'd1, 1'b0);
            n_res    = n_res + 3'd1;
            mode_d   = M_IDLE;
            la_cnt_d = 1'b0;
          end else begin
            if (c == "\\") esc_d = 1'b1;
            len_d = sat_add(len_d, 2'd1);
          end
        end
        M_SLASH: begin
          if (c == "/" || c == "*") begin
            mode_d   = (c == "/") ? M_LINE : M_BLOCK;
            len_d    = 16'd2;
            la_cnt_d = 1'b0;
          end else begin
            fall = 1'b1;
          end
        end
        M_EQ, M_BANG, M_LT, M_GT: begin
          if (c == "=") begin
            case (mode_d)
              M_EQ:    res[n_res[1:0]] = mk(K_EQ, start_d, 16'd2, 1'b0);
              M_BANG:  res[n_res[1:0]] = mk(K_NEQ, start_d, 16'd2, 1'b0);
              M_LT:    res[n_res[1:0]] = mk(K_LTEQ, start_d, 16'd2, 1'b0);
              default: res[n_res[1:0]] = mk(K_GTEQ, start_d, 16'd2, 1'b0);
            endcase
            n_res    = n_res + 3'd1;
            mode_d   = M_IDLE;
            la_cnt_d = 1'b0;
            esc_d    = 1'b0;
          end else begin
            fall = 1'b1;
          end
        end
        default: fall = 1'b1;
      endcase

      if (fall) begin
        f = flush_f(mode_d, start_d, len_d, dot_d, kw_d);
        if (f.n != 2'd0) begin
          res[n_res[1:0]] = f.a;
          n_res = n_res + 3'd1;
        end
        if (f.n == 2'd2) begin
          res[n_res[1:0]] = f.b;
          n_res = n_res + 3'd1;
        end
        mode_d   = M_IDLE;
        la_cnt_d = 1'b0;
        esc_d    = 1'b0;
        // The byte that ended the pending token now opens a new one.
        start_d  = off_d;
        len_d    = 16'd1;
        if (is_space(c)) begin
          mode_d = M_SPACE;
        end else if (c == "/") begin
          mode_d   = M_SLASH;
          la_d     = c;
          la_cnt_d = 1'b1;
        end else if (is_alpha(c)) begin
          mode_d = M_IDENT;
          kw_d   = {56'd0, c};
        end else if (is_digit(c)) begin
          mode_d = M_INT;
        end else if (c == "\"") begin
          res[n_res[1:0]] = mk(K_LSTR, off_d, 16'd1, 1'b0);
          n_res   = n_res + 3'd1;
          mode_d  = M_STRING;
          start_d = off_inc(off_d);
          len_d   = 16'd0;
        end else if (c == "=") begin
          mode_d = M_EQ;
        end else if (c == "!") begin
          mode_d = M_BANG;
        end else if (c == "<") begin
          mode_d = M_LT;
        end else if (c == ">") begin
          mode_d = M_GT;
        end else begin
          res[n_res[1:0]] = mk(punct_kind(c), off_d, 16'd1, 1'b0);
          n_res = n_res + 3'd1;
        end
      end
      off_d = off_inc(off_d);
    end

    if (in_item_i.end_of_text) begin
      err = (mode_d == M_STRING);
      f   = flush_f(mode_d, start_d, len_d, dot_d, kw_d);
      if (f.n != 2'd0) begin
        res[n_res[1:0]] = f.a;
        n_res = n_res + 3'd1;
      end
      if (f.n == 2'd2) begin
        res[n_res[1:0]] = f.b;
        n_res = n_res + 3'd1;
      end
      if (!err) begin
        res[n_res[1:0]] = mk(K_EOF, off_d, 16'd0, 1'b0);
        n_res = n_res + 3'd1;
      end
      mode_d   = M_IDLE;
      start_d  = '0;
      off_d    = '0;
      len_d    = '0;
      dot_d    = '0;
      la_cnt_d = 1'b0;
      kw_d     = '0;
      esc_d    = 1'b0;
    end
  end

  assign push_o       = accept && (n_res != 3'd0);
  assign run_o.res    = res;
  assign run_o.last_idx = 2'(n_res - 3'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= M_IDLE;
      start_q  <= '0;
      off_q    <= '0;
      len_q    <= '0;
      dot_q    <= '0;
      la_cnt_q <= 1'b0;
      kw_q     <= '0;
      esc_q    <= 1'b0;
    end else if (accept) begin
      mode_q   <= mode_d;
      start_q  <= start_d;
      off_q    <= off_d;
      len_q    <= len_d;
      dot_q    <= dot_d;
      la_cnt_q <= la_cnt_d;
      kw_q     <= kw_d;
      esc_q    <= esc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) la_q <= la_d;
  end

endmodule

// ===== hw/rtl/stl_back.sv =====
`include "script_token_lexer_macros.svh"

module stl_back
  import stl_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  run_t run_i,
  output logic ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output res_t out_item_o
);

  localparam int unsigned PtrW = $clog2(RunDepth);

  run_t                     runs_q [RunDepth];
  logic [PtrW-1:0]          wptr_q, rptr_q;
  logic [PtrW:0]            count_q;
  logic [$clog2(MaxRes)-1:0] idx_q;
  logic                     last_res;
  logic                     pop;
  run_t                     head;

  assign head        = runs_q[rptr_q];
  assign ready_o     = (count_q != (PtrW+1)'(RunDepth));
  assign out_valid_o = (count_q != '0);
  assign last_res    = (idx_q == head.last_idx);
  assign pop         = out_valid_o && out_ready_i && last_res;

  always_comb begin
    out_item_o             = head.res[idx_q];
    out_item_o.last_of_run = last_res;
  end

  always_ff @(posedge clk_i) begin
    if (push_i) runs_q[wptr_q] <= run_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
      idx_q   <= '0;
    end else begin
      if (push_i) wptr_q <= wptr_q + 1'b1;
      if (pop) rptr_q <= rptr_q + 1'b1;
      count_q <= count_q + (PtrW+1)'(push_i) - (PtrW+1)'(pop);
      if (out_valid_o && out_ready_i) begin
        idx_q <= last_res ? '0 : idx_q + 1'b1;
      end
    end
  end

  `STL_ASSERT(a_count_bound, count_q <= (PtrW+1)'(RunDepth), "run queue overflow")
  `STL_ASSERT(a_no_push_full, !(push_i && !ready_o), "push into a full run queue")
  `STL_ASSERT(a_idx_in_run, !out_valid_o || (idx_q <= head.last_idx), "result index past run")
  `STL_ASSERT_NEXT(a_pop_drains, pop && !push_i, count_q == $past(count_q) - 1'b1, "pop lost")

endmodule

// ===== hw/rtl/script_token_lexer.sv =====
// Streaming tokenizer: takes one source byte per item and returns tokens as kind, start
// offset and length, zero to four results per item, the last marked by last_of_run. Items
// that cause no result are not queued. An item is accepted every cycle while the four-entry
// run queue has room. Its results are queued when it is accepted and reach the output after
// earlier runs; each run drains at one result per cycle while out_ready_i is high, so
// throughput is one item per cycle whenever items average at most one result, and the
// output port sets the pace otherwise. Tokens whose end depends on a later byte appear with
// that later item. An item with end_of_text flushes pending tokens, emits EOF (or one error
// result for an unterminated string) and returns the lexer to its reset state.
module script_token_lexer
  import stl_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_item_t in_item_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output res_t     out_item_o
);

  logic push;
  run_t run;

  stl_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_i (in_ready_o),
    .in_item_i  (in_item_i),
    .push_o     (push),
    .run_o      (run)
  );

  stl_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .run_i       (run),
    .ready_o     (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

// ===== tb/tb_script_token_lexer.sv =====
module tb_script_token_lexer;
  import stl_pkg::*;

  localparam int unsigned IdleLimit = 5000;

  // Expected-token predictor: tracks the lexer state and queues expected results.
  class token_scoreboard;
    typedef enum logic [3:0] {
      LX_IDLE, LX_SPACE, LX_LINE, LX_BLOCK, LX_IDENT, LX_INT, LX_INT_DOT, LX_FRAC,
      LX_STRING, LX_SLASH, LX_EQ, LX_BANG, LX_LT, LX_GT
    } lex_mode_e;

    lex_mode_e   mode;
    logic [15:0] tok_start;
    logic [15:0] offset;
    logic [16:0] tok_len;
    logic [15:0] dot_off;
    logic [63:0] kw_buf;
    logic        star_seen;
    logic        escape;
    res_t        step_q[$];
    res_t        token_q[$];
    int          errors;
    int          checked;

    function new();
      errors = 0;
      checked = 0;
      clear();
    endfunction

    function void clear();
      mode = LX_IDLE;
      tok_start = '0;
      offset = '0;
      tok_len = '0;
      dot_off = '0;
      kw_buf = '0;
      star_seen = 1'b0;
      escape = 1'b0;
    endfunction

    function logic [16:0] sat_add(logic [16:0] v, int d);
      logic [17:0] s;
      s = {1'b0, v} + 18'(d);
      return (s > 18'hFFFF) ? 17'hFFFF : s[16:0];
    endfunction

    function logic [15:0] next_off(logic [15:0] v);
      return (v < OffsetCap) ? v + 16'd1 : OffsetCap;
    endfunction

    function void push(logic [5:0] kind, logic [15:0] start, logic [16:0] len, logic err);
      res_t r;
      if (step_q.size() >= MaxRes) return;
      r.token_kind = kind;
      r.token_start = start;
      r.token_length = len[15:0];
      r.lex_error = err;
      r.last_of_run = 1'b0;
      step_q.push_back(r);
    endfunction

    function logic [63:0] pack_word(string s);
      logic [63:0] w;
      w = '0;
      for (int i = 0; i < s.len(); i++) w[8*i +: 8] = s[i];
      return w;
    endfunction

    function logic [5:0] keyword_kind();
      string kw[21];
      logic [5:0] kk[21];
      kw = '{"fn", "var", "const", "if", "else", "for", "while", "try", "catch", "return",
             "break", "continue", "none", "true", "false", "is", "as", "typeof", "and",
             "or", "not"};
      kk = '{K_FN, K_VAR, K_CONST, K_IF, K_ELSE, K_FOR, K_WHILE, K_TRY, K_CATCH, K_RETURN,
             K_BREAK, K_CONTINUE, K_NONE, K_TRUE, K_FALSE, K_IS, K_AS, K_TYPEOF, K_AND,
             K_OR, K_NOT};
      if (tok_len > 8) return K_IDENT;
      for (int i = 0; i < 21; i++)
        if (kw[i].len() == tok_len && pack_word(kw[i]) == kw_buf) return kk[i];
      return K_IDENT;
    endfunction

    function bit is_space(logic [7:0] c);
      return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function bit is_alpha(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function bit is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
    endfunction

    function void go_idle();
      mode = LX_IDLE;
      star_seen = 1'b0;
      escape = 1'b0;
    endfunction

    function void flush();
      case (mode)
        LX_SPACE: push(K_WHITESPACE, tok_start, tok_len, 1'b0);
        LX_LINE, LX_BLOCK: push(K_COMMENT, tok_start, tok_len, 1'b0);
        LX_IDENT: push(keyword_kind(), tok_start, tok_len, 1'b0);
        LX_INT: push(K_INTEGER, tok_start, tok_len, 1'b0);
        LX_INT_DOT: begin
          push(K_INTEGER, tok_start, tok_len, 1'b0);
          push(K_DOT, dot_off, 17'd1, 1'b0);
        end
        LX_FRAC: push(K_NUMBER, tok_start, tok_len, 1'b0);
        LX_STRING: push(K_INVALID, tok_start, tok_len, 1'b1);
        LX_SLASH: push(K_SLASH, tok_start, 17'd1, 1'b0);
        LX_EQ: push(K_ASSIGN, tok_start, 17'd1, 1'b0);
        LX_BANG: push(K_INVALID, tok_start, 17'd1, 1'b0);
        LX_LT: push(K_LT, tok_start, 17'd1, 1'b0);
        LX_GT: push(K_GT, tok_start, 17'd1, 1'b0);
        default: ;
      endcase
      go_idle();
    endfunction

    function logic [5:0] punct(logic [7:0] c);
      case (c)
        "(": return K_LPAREN;    ")": return K_RPAREN;
        "[": return K_LBRACKET;  "]": return K_RBRACKET;
        "{": return K_LBRACE;    "}": return K_RBRACE;
        ",": return K_COMMA;     "#": return K_HASH;
        ".": return K_DOT;       ":": return K_COLON;
        ";": return K_SEMICOLON; "+": return K_PLUS;
        "-": return K_MINUS;     "*": return K_STAR;
        "%": return K_PERCENT;   "~": return K_TILDE;
        "&": return K_AMPERSAND; "|": return K_PIPE;
        "^": return K_CARET;
        default: return K_INVALID;
      endcase
    endfunction

    function void begin_token(logic [7:0] c, logic [15:0] off);
      tok_start = off;
      tok_len = 17'd1;
      if (is_space(c)) mode = LX_SPACE;
      else if (c == "/") mode = LX_SLASH;
      else if (is_alpha(c)) begin
        mode = LX_IDENT;
        kw_buf = {56'd0, c};
      end else if (is_digit(c)) mode = LX_INT;
      else if (c == "\"") begin
        push(K_LSTR, off, 17'd1, 1'b0);
        mode = LX_STRING;
        tok_start = next_off(off);
        tok_len = '0;
        escape = 1'b0;
      end else if (c == "=") mode = LX_EQ;
      else if (c == "!") mode = LX_BANG;
      else if (c == "<") mode = LX_LT;
      else if (c == ">") mode = LX_GT;
      else push(punct(c), off, 17'd1, 1'b0);
    endfunction

    function void pair(logic [5:0] kind);
      push(kind, tok_start, 17'd2, 1'b0);
      go_idle();
    endfunction

    // Returns 1 when the byte was absorbed by the current token.
    function bit absorb(logic [7:0] c, logic [15:0] off);
      case (mode)
        LX_SPACE: if (is_space(c)) begin tok_len = sat_add(tok_len, 1); return 1; end
        LX_LINE: if (c != 8'h0A) begin tok_len = sat_add(tok_len, 1); return 1; end
        LX_BLOCK: begin
          tok_len = sat_add(tok_len, 1);
          if (star_seen && c == "/") begin
            push(K_COMMENT, tok_start, tok_len, 1'b0);
            go_idle();
          end else star_seen = (c == "*");
          return 1;
        end
        LX_IDENT: if (is_alpha(c) || is_digit(c) || c == "_") begin
          if (tok_len < 8) kw_buf[8*tok_len[2:0] +: 8] = c;
          tok_len = sat_add(tok_len, 1);
          return 1;
        end
        LX_INT: begin
          if (is_digit(c)) begin tok_len = sat_add(tok_len, 1); return 1; end
          if (c == ".") begin mode = LX_INT_DOT; dot_off = off; return 1; end
        end
        LX_INT_DOT: if (is_digit(c)) begin
          tok_len = sat_add(tok_len, 2);
          mode = LX_FRAC;
          return 1;
        end
        LX_FRAC: if (is_digit(c)) begin tok_len = sat_add(tok_len, 1); return 1; end
        LX_STRING: begin
          if (escape) escape = 1'b0;
          else if (c == "\"") begin
            push(K_SPAN, tok_start, tok_len, 1'b0);
            push(K_RSTR, off, 17'd1, 1'b0);
            go_idle();
            return 1;
          end else if (c == "\\") escape = 1'b1;
          tok_len = sat_add(tok_len, 1);
          return 1;
        end
        LX_SLASH: if (c == "/" || c == "*") begin
          mode = (c == "/") ? LX_LINE : LX_BLOCK;
          tok_len = 17'd2;
          star_seen = 1'b0;
          return 1;
        end
        LX_EQ: if (c == "=") begin pair(K_EQ); return 1; end
        LX_BANG: if (c == "=") begin pair(K_NEQ); return 1; end
        LX_LT: if (c == "=") begin pair(K_LTEQ); return 1; end
        LX_GT: if (c == "=") begin pair(K_GTEQ); return 1; end
        default: ;
      endcase
      return 0;
    endfunction

    function void note_item(in_item_t it);
      bit err;
      step_q.delete();
      if (it.byte_valid) begin
        if (!absorb(it.char_byte, offset)) begin
          flush();
          begin_token(it.char_byte, offset);
        end
        offset = next_off(offset);
      end
      if (it.end_of_text) begin
        err = (mode == LX_STRING);
        flush();
        if (!err) push(K_EOF, offset, 17'd0, 1'b0);
        clear();
      end
      if (step_q.size() > 0) step_q[step_q.size()-1].last_of_run = 1'b1;
      foreach (step_q[i]) token_q.push_back(step_q[i]);
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (token_q.size() == 0) begin
        $display("%0t: unexpected result, actual %p", $realtime, got);
        errors++;
        return;
      end
      want = token_q.pop_front();
      checked++;
      if (got !== want) begin
        $display("%0t: result mismatch, expected %p, actual %p", $realtime, want, got);
        errors++;
      end
    endfunction
  endclass

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  in_item_t in_item;
  logic     out_valid;
  logic     out_ready;
  res_t     out_item;

  token_scoreboard tokens;
  bit   calm;
  bit   hold_output;
  int   idle_cycles;
  int   items_sent;

  script_token_lexer i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Sample both handshakes at the rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) tokens.note_item(in_item);
      if (out_valid && out_ready) tokens.check_result(out_item);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  always @(posedge clk) begin
    if (idle_cycles >= IdleLimit) begin
      $display("Watchdog expired after %0d idle cycles", idle_cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  // Output side: random stall bursts, a long hold when requested.
  initial begin
    int n;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_output) begin
        out_ready <= 1'b0;
        for (n = 0; n < 60; n++) @(negedge clk);
        hold_output = 1'b0;
      end
      if (!calm && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        n = $urandom_range(1, 4);
        repeat (n - 1) @(negedge clk);
      end else out_ready <= 1'b1;
    end
  end

  // Valid stays high from one item to the next unless an idle burst is drawn.
  task automatic send_item(logic [7:0] c, logic v, logic eot);
    in_item_t it;
    if (!calm && $urandom_range(0, 6) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    it.char_byte = c;
    it.byte_valid = v;
    it.end_of_text = eot;
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic send_text(string s, bit finish_text);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b1, finish_text && i == s.len() - 1);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (tokens.token_q.size() != 0) @(negedge clk);
  endtask

  function automatic logic [7:0] pick_byte();
    string alphabet;
    alphabet = "abcfnoirstuvwxyzeEZ_09583 \t\n/*\"\\=!<>.()[]{},#:;+-%~&|^@$?";
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
    return alphabet[$urandom_range(0, alphabet.len() - 1)];
  endfunction

  function automatic string pick_fragment();
    string frags[24];
    frags = '{"fn ", "var x1 = 42;", "const", "if(a<=b)", "else{", "for ", "while ",
              "try ", "catch", "return 3.14", "break;", "continue", "none", "true",
              "false", "is", "as", "typeof", "and", "or", "not", "// hi\n",
              "/* c * / */", "\"s\\\"q\" != 7. >= x"};
    return frags[$urandom_range(0, 23)];
  endfunction

  initial begin
    string s;
    int n;
    tokens = new();
    calm = 1'b0;
    hold_output = 1'b0;
    idle_cycles = 0;
    items_sent = 0;
    in_valid = 1'b0;
    in_item = '0;
    rst_n = 1'b0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed: keywords, comparisons, dot handling, comments, strings, byte extremes.
    send_text("continue typeof fn x", 1'b1);
    send_text("12.5 7.a 9.", 1'b1);
    send_text("== != <= >= = ! < > /", 1'b1);
    send_text("//line\n/* a **/ /* open", 1'b1);
    send_text("\"a\\\"b\" \"", 1'b1);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'h41, 1'b0, 1'b1);
    wait_drained();

    // Long output stall with the sender still offering items.
    hold_output = 1'b1;
    send_text("(){}[],#:;+-*%~&|^ abcdefghij", 1'b1);
    wait_drained();

    // Random: mostly well-formed fragments, some noise and empty items.
    while (items_sent < 480) begin
      if (items_sent > 400) calm = 1'b1;
      n = $urandom_range(1, 6);
      for (int f = 0; f < n && items_sent < 480; f++) begin
        if ($urandom_range(0, 3) == 0) begin
          s = "";
          repeat ($urandom_range(1, 6)) s = {s, string'(pick_byte())};
        end else s = {pick_fragment(), " "};
        send_text(s, 1'b0);
        if ($urandom_range(0, 15) == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      end
      send_item(pick_byte(), 1'($urandom_range(0, 1)), 1'b1);
    end

    wait_drained();
    repeat (20) @(negedge clk);
    $display("Sent %0d items with keywords, numbers, comments, strings and stalls;",
             items_sent);
    $display("checked %0d tokens.", tokens.checked);
    if (tokens.errors == 0 && tokens.token_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
